// ===== rtl/rsi_pkg.sv =====
// Shared constants, types and step functions for the ray-sphere intersection pipeline.
`default_nettype none
package rsi_pkg;

	// Stage map of the pipeline
	localparam int NS         = 35;
	localparam int SQ_FIRST   = 6;
	localparam int SQ_STAGES  = 18;
	localparam int SQ_PER     = 2;
	localparam int ST_ROOTS   = SQ_FIRST + SQ_STAGES;
	localparam int ST_SELECT  = ST_ROOTS + 1;
	localparam int ST_TMUL    = ST_SELECT + 1;
	localparam int ST_POINT   = ST_TMUL + 1;
	localparam int ST_DIFF    = ST_POINT + 1;
	localparam int DIV_FIRST  = ST_DIFF + 1;
	localparam int DIV_STAGES = 6;
	localparam int DIV_PER    = 3;
	localparam int DIV_BITS   = 17;

	localparam logic [17:0] NORM_ONE = 18'h10000;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_RADIUS   = 3'd3,
		REG_T_MIN    = 3'd4,
		REG_T_MAX    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [39:0] rem;
		logic [35:0] root;
		logic [71:0] x;
	} sq_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [16:0] q;
	} dv_t;

	// One digit of the restoring square root
	function automatic sq_t sq_step(input sq_t a);
		sq_t r;
		logic [39:0] r2;
		logic [39:0] tr;
		r2 = {a.rem[37:0], a.x[71:70]};
		tr = {2'b00, a.root, 2'b01};
		if (r2 >= tr) begin
			r.rem  = r2 - tr;
			r.root = {a.root[34:0], 1'b1};
		end else begin
			r.rem  = r2;
			r.root = {a.root[34:0], 1'b0};
		end
		r.x = {a.x[69:0], 2'b00};
		return r;
	endfunction

	// One quotient bit of the restoring divider
	function automatic dv_t dv_step(input dv_t a, input logic [30:0] d);
		dv_t r;
		logic [33:0] nr;
		logic b;
		b  = (a.rem >= {3'b000, d});
		nr = b ? (a.rem - {3'b000, d}) : a.rem;
		r.rem = {nr[32:0], 1'b0};
		r.q   = {a.q[15:0], b};
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ray_sphere_intersection.sv =====
// Ray-sphere intersection: top level with the full arithmetic pipeline.
// Tests one ray per cycle, while the output is not stalled, against the configured sphere
// and returns one result word per ray. The pipeline has 35 register stages; a new ray can
// be taken every cycle that in_ready is high. Depth is set by the 18-stage square-root
// pipeline (two root digits per stage) and the 6-stage normal divider (three quotient bits
// per stage, two in the last). Each stage advances on its own when the next one has room,
// so bubbles collapse and a stalled output holds only the words behind it. Positions, radius
// and distance are Q16.16, direction and normal components Q2.16; point components saturate,
// normal components clamp to [-1.0, 1.0]. Registers: APB byte addresses 0, 4, 8, 12, 16, 20.
`default_nettype none
module ray_sphere_intersection (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	input  wire logic signed [31:0] origin_z,
	input  wire logic signed [17:0] dir_x,
	input  wire logic signed [17:0] dir_y,
	input  wire logic signed [17:0] dir_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    hit,
	output logic [30:0]             hit_distance,
	output logic signed [31:0]      point_x,
	output logic signed [31:0]      point_y,
	output logic signed [31:0]      point_z,
	output logic signed [17:0]      normal_x,
	output logic signed [17:0]      normal_y,
	output logic signed [17:0]      normal_z
);
	import rsi_pkg::*;

	typedef struct {
		logic signed [31:0] o [3];
		logic signed [17:0] d [3];
		logic signed [32:0] oc [3];
		logic signed [35:0] pd [3];
		logic [49:0]        po [3];
		logic [45:0]        rr;
		logic signed [37:0] hb;
		logic signed [53:0] cc;
		logic [59:0]        hb2;
		logic               miss;
		sq_t                sq;
		logic signed [38:0] t1;
		logic signed [38:0] t2;
		logic               hit;
		logic [30:0]        t;
		logic signed [33:0] td [3];
		logic signed [31:0] p [3];
		logic               dneg [3];
		logic               sat [3];
		dv_t                dv [3];
		logic signed [17:0] n [3];
	} pipe_t;

	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic [30:0]        radius_q, t_min_q, t_max_q;

	pipe_t       pipe_s [1:NS];
	pipe_t       nxt [1:NS];
	logic [NS:1] vld_s;
	logic [NS:1] en;

	logic signed [31:0] cen [3];
	logic signed [31:0] o_in [3];
	logic signed [17:0] d_in [3];

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= 31'd65536;
			t_min_q    <= 31'd66;
			t_max_q    <= 31'h7FFF_FFFF;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_CENTER_X: center_x_q <= pwdata;
				REG_CENTER_Y: center_y_q <= pwdata;
				REG_CENTER_Z: center_z_q <= pwdata;
				REG_RADIUS:   radius_q   <= pwdata[30:0];
				REG_T_MIN:    t_min_q    <= pwdata[30:0];
				REG_T_MAX:    t_max_q    <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_CENTER_X: prdata = center_x_q;
			REG_CENTER_Y: prdata = center_y_q;
			REG_CENTER_Z: prdata = center_z_q;
			REG_RADIUS:   prdata = {1'b0, radius_q};
			REG_T_MIN:    prdata = {1'b0, t_min_q};
			REG_T_MAX:    prdata = {1'b0, t_max_q};
			default:      prdata = '0;
		endcase
	end

	assign cen[0]  = center_x_q;
	assign cen[1]  = center_y_q;
	assign cen[2]  = center_z_q;
	assign o_in[0] = origin_x;
	assign o_in[1] = origin_y;
	assign o_in[2] = origin_z;
	assign d_in[0] = dir_x;
	assign d_in[1] = dir_y;
	assign d_in[2] = dir_z;

	// Stage enables: a stage loads when it is empty or its word moves on
	always_comb begin
		en[NS] = !vld_s[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k + 1];
		end
	end

	assign in_ready = en[1];

	// Datapath
	always_comb begin
		logic [17:0]        dmag;
		logic [32:0]        omag;
		logic [50:0]        m1;
		logic [65:0]        m2;
		logic [61:0]        m3;
		logic [37:0]        hmag;
		logic [75:0]        m4;
		logic [51:0]        posum;
		logic signed [60:0] disc;
		logic               in1, in2;
		logic [48:0]        m5;
		logic signed [34:0] psum;
		logic signed [32:0] diff;
		logic [32:0]        dm;
		logic [17:0]        nmag;

		nxt[1] = pipe_s[1];
		for (int k = 2; k <= NS; k++) begin
			nxt[k] = pipe_s[k - 1];
		end

		// Offset from the center
		for (int i = 0; i < 3; i++) begin
			nxt[1].o[i]  = o_in[i];
			nxt[1].d[i]  = d_in[i];
			nxt[1].oc[i] = 33'(o_in[i]) - 33'(cen[i]);
		end

		// Dot products and squares, truncated toward zero
		for (int i = 0; i < 3; i++) begin
			dmag = pipe_s[1].d[i][17] ? 18'(-pipe_s[1].d[i]) : 18'(pipe_s[1].d[i]);
			omag = pipe_s[1].oc[i][32] ? 33'(-pipe_s[1].oc[i]) : 33'(pipe_s[1].oc[i]);
			m1 = 51'(dmag) * 51'(omag);
			m2 = 66'(omag) * 66'(omag);
			nxt[2].pd[i] = (pipe_s[1].d[i][17] ^ pipe_s[1].oc[i][32])
				? -$signed({1'b0, m1[50:16]}) : $signed({1'b0, m1[50:16]});
			nxt[2].po[i] = m2[65:16];
		end
		m3 = 62'(radius_q) * 62'(radius_q);
		nxt[2].rr = m3[61:16];

		// Half b and c of the quadratic
		nxt[3].hb = 38'(pipe_s[2].pd[0]) + 38'(pipe_s[2].pd[1]) + 38'(pipe_s[2].pd[2]);
		posum = 52'(pipe_s[2].po[0]) + 52'(pipe_s[2].po[1]) + 52'(pipe_s[2].po[2]);
		nxt[3].cc = $signed({2'b00, posum}) - $signed({8'h00, pipe_s[2].rr});

		hmag = pipe_s[3].hb[37] ? 38'(-pipe_s[3].hb) : 38'(pipe_s[3].hb);
		m4 = 76'(hmag) * 76'(hmag);
		nxt[4].hb2 = m4[75:16];

		// Discriminant; seed the root
		disc = $signed({1'b0, pipe_s[4].hb2}) - 61'(pipe_s[4].cc);
		nxt[5].miss    = disc[60];
		nxt[5].sq.x    = {disc[55:0], 16'h0000};
		nxt[5].sq.rem  = '0;
		nxt[5].sq.root = '0;

		for (int k = SQ_FIRST; k < SQ_FIRST + SQ_STAGES; k++) begin
			for (int j = 0; j < SQ_PER; j++) begin
				nxt[k].sq = sq_step(nxt[k].sq);
			end
		end

		nxt[ST_ROOTS].t1 = -39'(pipe_s[ST_ROOTS - 1].hb)
			- $signed({3'b000, pipe_s[ST_ROOTS - 1].sq.root});
		nxt[ST_ROOTS].t2 = -39'(pipe_s[ST_ROOTS - 1].hb)
			+ $signed({3'b000, pipe_s[ST_ROOTS - 1].sq.root});

		// Pick the nearer root inside the window
		in1 = (pipe_s[ST_ROOTS].t1 >= $signed({8'h00, t_min_q}))
			&& (pipe_s[ST_ROOTS].t1 <= $signed({8'h00, t_max_q}));
		in2 = (pipe_s[ST_ROOTS].t2 >= $signed({8'h00, t_min_q}))
			&& (pipe_s[ST_ROOTS].t2 <= $signed({8'h00, t_max_q}));
		nxt[ST_SELECT].hit = !pipe_s[ST_ROOTS].miss && (in1 || in2);
		nxt[ST_SELECT].t   = in1 ? pipe_s[ST_ROOTS].t1[30:0] : pipe_s[ST_ROOTS].t2[30:0];

		for (int i = 0; i < 3; i++) begin
			dmag = pipe_s[ST_SELECT].d[i][17]
				? 18'(-pipe_s[ST_SELECT].d[i]) : 18'(pipe_s[ST_SELECT].d[i]);
			m5 = 49'(dmag) * 49'(pipe_s[ST_SELECT].t);
			nxt[ST_TMUL].td[i] = pipe_s[ST_SELECT].d[i][17]
				? -$signed({1'b0, m5[48:16]}) : $signed({1'b0, m5[48:16]});
		end

		// Hit point, saturated to 32 bits
		for (int i = 0; i < 3; i++) begin
			psum = 35'(pipe_s[ST_TMUL].o[i]) + 35'(pipe_s[ST_TMUL].td[i]);
			if (psum[34:31] == 4'b0000 || psum[34:31] == 4'b1111) begin
				nxt[ST_POINT].p[i] = psum[31:0];
			end else begin
				nxt[ST_POINT].p[i] = psum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end
		end

		// Seed the normal divider; quotients of 2.0 and above clamp anyway
		for (int i = 0; i < 3; i++) begin
			diff = 33'(pipe_s[ST_POINT].p[i]) - 33'(cen[i]);
			dm   = diff[32] ? 33'(-diff) : 33'(diff);
			nxt[ST_DIFF].dneg[i]  = diff[32];
			nxt[ST_DIFF].sat[i]   = (dm >= {1'b0, radius_q, 1'b0});
			nxt[ST_DIFF].dv[i].rem = {1'b0, dm};
			nxt[ST_DIFF].dv[i].q   = '0;
		end

		for (int s = 0; s < DIV_STAGES; s++) begin
			for (int b = 0; b < DIV_PER; b++) begin
				if (s * DIV_PER + b < DIV_BITS) begin
					for (int i = 0; i < 3; i++) begin
						nxt[DIV_FIRST + s].dv[i] =
							dv_step(nxt[DIV_FIRST + s].dv[i], radius_q);
					end
				end
			end
		end

		// Clamp and sign the normal; zero everything on a miss
		for (int i = 0; i < 3; i++) begin
			if (pipe_s[NS - 1].sat[i] || ({1'b0, pipe_s[NS - 1].dv[i].q} > NORM_ONE)) begin
				nmag = NORM_ONE;
			end else begin
				nmag = {1'b0, pipe_s[NS - 1].dv[i].q};
			end
			if (radius_q == '0 || !pipe_s[NS - 1].hit) begin
				nxt[NS].n[i] = '0;
			end else begin
				nxt[NS].n[i] = pipe_s[NS - 1].dneg[i] ? -$signed(nmag) : $signed(nmag);
			end
			if (!pipe_s[NS - 1].hit) begin
				nxt[NS].p[i] = '0;
			end
		end
		if (!pipe_s[NS - 1].hit) begin
			nxt[NS].t = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NS; k++) begin
			if (en[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	assign out_valid    = vld_s[NS];
	assign hit          = pipe_s[NS].hit;
	assign hit_distance = pipe_s[NS].t;
	assign point_x      = pipe_s[NS].p[0];
	assign point_y      = pipe_s[NS].p[1];
	assign point_z      = pipe_s[NS].p[2];
	assign normal_x     = pipe_s[NS].n[0];
	assign normal_y     = pipe_s[NS].n[1];
	assign normal_z     = pipe_s[NS].n[2];

endmodule
`default_nettype wire

// ===== rtl/rsi_checker.sv =====
// Port-level assertions for the ray-sphere intersection block, bound to its top level.
`default_nettype none
module rsi_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               hit,
	input wire logic [30:0]        hit_distance,
	input wire logic signed [31:0] point_x,
	input wire logic signed [31:0] point_y,
	input wire logic signed [31:0] point_z,
	input wire logic signed [17:0] normal_x,
	input wire logic signed [17:0] normal_y,
	input wire logic signed [17:0] normal_z
);
	import rsi_pkg::*;

	// Hold the hit flag, distance, point_x and normal_x of a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_distance)
			&& $stable(point_x) && $stable(normal_x))
		else $error("stalled result word changed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_distance == '0 && point_x == '0 && point_y == '0
			&& point_z == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("miss carries nonzero fields");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> normal_x <= $signed(NORM_ONE) && normal_x >= -$signed(NORM_ONE)
			&& normal_y <= $signed(NORM_ONE) && normal_y >= -$signed(NORM_ONE)
			&& normal_z <= $signed(NORM_ONE) && normal_z >= -$signed(NORM_ONE))
		else $error("normal component outside unit range");

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (.*);
`default_nettype wire
